>>> sv/snt_pkg.sv
// Shared types, constants and codes for the sorted name table.
`default_nettype none
package snt_pkg;

	// Table geometry.
	localparam int ENTRIES    = 128;
	localparam int KEY_CHARS  = 8;
	localparam int NAME_W     = 64;
	localparam int AVG_W      = 10;
	localparam int KIND_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int GROUP_SIZE = 16;
	localparam int GROUPS     = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

	localparam logic [NAME_W-1:0] KEY_MASK = {NAME_W{1'b1}} << (8 * (8 - KEY_CHARS));
	localparam logic [AVG_W-1:0]  AVG_MAX  = AVG_W'(1000);

	// Operation codes.
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

	// Result codes.
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NAME_W-1:0] family_name;
		logic [NAME_W-1:0] given_name;
		logic [AVG_W-1:0]  grade_average;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [AVG_W-1:0]    found_average;
	} out_item_t;

	// One stored record.
	typedef struct packed {
		logic [NAME_W-1:0] family;
		logic [NAME_W-1:0] given;
		logic [AVG_W-1:0]  avg;
	} entry_t;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		logic   cmp_en;
		logic   insert;
		logic   update;
		entry_t key;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SUM,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

>>> sv/snt_cell.sv
// One cell of the sorted record chain: storage, key compare and shift.
`default_nettype none
module snt_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  snt_pkg::cell_ctrl_t ctrl,
	input  wire                 occupied,
	input  snt_pkg::entry_t     left_entry,
	input  wire                 left_after,
	output snt_pkg::entry_t     entry,
	output logic                after_s1,
	output logic                eq_s1
);
	import snt_pkg::*;

	entry_t                entry_q;
	logic [2*NAME_W-1:0]   own_key;
	logic [2*NAME_W-1:0]   new_key;
	logic                  greater;
	logic                  equal;

	assign own_key = {entry_q.family, entry_q.given};
	assign new_key = {ctrl.key.family, ctrl.key.given};
	assign greater = occupied && (own_key > new_key);
	assign equal   = occupied && (own_key == new_key);
	assign entry   = entry_q;

	// The key belongs at or before this cell when the cell is empty or larger.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_s1 <= 1'b0;
			eq_s1    <= 1'b0;
		end else if (ctrl.cmp_en) begin
			after_s1 <= greater || !occupied;
			eq_s1    <= equal;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (left_after) begin
				entry_q <= left_entry;
			end else if (after_s1) begin
				entry_q <= ctrl.key;
			end
		end else if (ctrl.update && eq_s1) begin
			entry_q.avg <= ctrl.key.avg;
		end
	end

endmodule
`default_nettype wire

>>> sv/snt_match_tree.sv
// Registered first level of the match and average collection tree.
`default_nettype none
module snt_match_tree (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       en,
	input  wire                       eq [snt_pkg::ENTRIES],
	input  wire [snt_pkg::AVG_W-1:0]  avgs [snt_pkg::ENTRIES],
	output logic                      grp_hit_s2 [snt_pkg::GROUPS],
	output logic [snt_pkg::AVG_W-1:0] grp_avg_s2 [snt_pkg::GROUPS]
);
	import snt_pkg::*;

	logic             hit_c [GROUPS];
	logic [AVG_W-1:0] avg_c [GROUPS];

	// At most one cell matches, so an OR of the gated averages selects it.
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			hit_c[g] = 1'b0;
			avg_c[g] = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (g * GROUP_SIZE + k < ENTRIES) begin
					if (eq[g * GROUP_SIZE + k]) begin
						hit_c[g] = 1'b1;
						avg_c[g] = avg_c[g] | avgs[g * GROUP_SIZE + k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GROUPS; g++) begin
				grp_hit_s2[g] <= 1'b0;
			end
		end else if (en) begin
			for (int g = 0; g < GROUPS; g++) begin
				grp_hit_s2[g] <= hit_c[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < GROUPS; g++) begin
				grp_avg_s2[g] <= avg_c[g];
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/sorted_name_table_lookup.sv
// Top level of the sorted name table: sequencer, cell chain and result register.
//
// The block keeps up to ENTRIES records sorted by family name, then given
// name, in a chain of cells. Commands arrive on the input channel (in_valid,
// in_stall, in_data); every command yields exactly one result transfer on
// the output channel (out_valid, out_stall, out_data).
// Clear empties the table. Insert adds a record at its sorted position,
// shifting the larger records one cell to the right, or replaces the
// average of a record with the same key; it reports full when a new key
// does not fit. Lookup returns the average of the matching record or
// reports not found.
// Each command passes through the accepting idle state, a compare of the
// key against every cell, a registered collection of the per-cell match
// flags in groups, and a final state that updates the cells and loads the
// result register. A new command is taken only back in idle, so the block
// does not take a command before the last one is through. The result
// register holds a pending result while out_stall is high, and the block
// then waits in its final state before writing.
// Reset empties the table and drops any pending result; record contents
// need no reset because only occupied cells are ever compared.
`default_nettype none
module sorted_name_table_lookup (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  snt_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  wire                out_stall,
	output snt_pkg::out_item_t out_data
);
	import snt_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [KIND_W-1:0] kind_q;
	entry_t           key_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	out_item_t        out_data_q;

	cell_ctrl_t       ctrl;
	entry_t           cell_entry [ENTRIES];
	logic             cell_after [ENTRIES];
	logic             cell_eq [ENTRIES];
	logic [AVG_W-1:0] cell_avg [ENTRIES];
	logic             grp_hit_s2 [GROUPS];
	logic [AVG_W-1:0] grp_avg_s2 [GROUPS];

	logic             accept;
	logic             finish;
	logic             hit;
	logic [AVG_W-1:0] hit_avg;
	logic             full;
	logic             is_insert;
	out_item_t        result;

	assign accept = in_valid && !in_stall;
	assign full   = (count_q == CNT_W'(ENTRIES));

	// The result register may be loaded when empty or when its content leaves now.
	assign finish = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: state_d = ST_SUM;
			ST_SUM: state_d = ST_FIN;
			ST_FIN: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Command register: the key is masked to its significant characters and
	// the average is saturated before it can reach a cell.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q        <= in_data.kind;
			key_q.family  <= in_data.family_name & KEY_MASK;
			key_q.given   <= in_data.given_name & KEY_MASK;
			key_q.avg     <= (in_data.grade_average > AVG_MAX) ? AVG_MAX : in_data.grade_average;
		end
	end

	// Final level of the match collection.
	always_comb begin
		hit     = 1'b0;
		hit_avg = '0;
		for (int g = 0; g < GROUPS; g++) begin
			hit     = hit | grp_hit_s2[g];
			hit_avg = hit_avg | grp_avg_s2[g];
		end
	end

	assign is_insert = (kind_q == KIND_INSERT);

	always_comb begin
		ctrl        = '0;
		ctrl.key    = key_q;
		ctrl.cmp_en = (state_q == ST_CMP);
		ctrl.insert = finish && is_insert && !hit && !full;
		ctrl.update = finish && is_insert && hit;
	end

	always_comb begin
		result = '0;
		case (kind_q)
			KIND_INSERT: begin
				if (!hit && full) begin
					result.status = STATUS_FULL;
				end
			end
			KIND_LOOKUP: begin
				if (hit) begin
					result.found_average = hit_avg;
				end else begin
					result.status = STATUS_NOT_FOUND;
				end
			end
			default: result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (finish) begin
			if (kind_q == KIND_CLEAR) begin
				count_q <= '0;
			end else if (is_insert && !hit && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// The chain of cells; cell zero has no left neighbor.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		entry_t left_entry;
		logic   left_after;

		if (i == 0) begin : g_first
			assign left_entry = '0;
			assign left_after = 1'b0;
		end else begin : g_rest
			assign left_entry = cell_entry[i-1];
			assign left_after = cell_after[i-1];
		end

		snt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.occupied   (CNT_W'(i) < count_q),
			.left_entry (left_entry),
			.left_after (left_after),
			.entry      (cell_entry[i]),
			.after_s1   (cell_after[i]),
			.eq_s1      (cell_eq[i])
		);

		assign cell_avg[i] = cell_entry[i].avg;
	end

	snt_match_tree u_tree (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (state_q == ST_SUM),
		.eq         (cell_eq),
		.avgs       (cell_avg),
		.grp_hit_s2 (grp_hit_s2),
		.grp_avg_s2 (grp_avg_s2)
	);

	// Result register between the table and the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The record count never passes the table size.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("record count above table size");

	// A command transfer always starts the compare cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CMP)
		else $error("accepted command did not start a compare");

	// A result appears only out of the final cycle of a command.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result without a finished command");

	// An insert into a full table leaves the count alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		(finish && is_insert && full) |=> count_q == $past(count_q))
		else $error("full table grew on insert");

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the sorted name table: a scoreboard model, directed and random commands.
`timescale 1ns / 1ps
module testbench;
	import snt_pkg::*;

	// Unused operation code; the block must answer it with a plain OK.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [NAME_W-1:0] NAME_ONES   = {NAME_W{1'b1}};
	localparam int RANDOM_OPS  = 1050;
	localparam int POOL_DEPTH  = ENTRIES + 32;
	localparam int HOLD_CYCLES = 300;

	// The scoreboard keeps its own sorted copy of the table. Every accepted
	// command updates that copy and queues the reply the block must give.
	class table_scoreboard;
		logic [NAME_W-1:0] family_keys[ENTRIES];
		logic [NAME_W-1:0] given_keys[ENTRIES];
		logic [AVG_W-1:0]  averages[ENTRIES];
		int                used;
		out_item_t         expected_replies[$];
		int                failures;

		function new();
			used = 0;
			failures = 0;
		endfunction

		// Binary search over the occupied part of the table. On a miss, pos
		// is the slot where the key belongs.
		function bit find_key(input logic [2*NAME_W-1:0] key, output int pos);
			int lo;
			int hi;
			int mid;
			lo = 0;
			hi = used;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if ({family_keys[mid], given_keys[mid]} == key) begin
					pos = mid;
					return 1'b1;
				end
				if ({family_keys[mid], given_keys[mid]} > key)
					hi = mid;
				else
					lo = mid + 1;
			end
			pos = lo;
			return 1'b0;
		endfunction

		function void note_command(input in_item_t cmd);
			logic [2*NAME_W-1:0] key;
			logic [AVG_W-1:0]    avg;
			int                  pos;
			out_item_t           reply;
			key = {cmd.family_name & KEY_MASK, cmd.given_name & KEY_MASK};
			avg = (cmd.grade_average > AVG_MAX) ? AVG_MAX : cmd.grade_average;
			reply.status = STATUS_OK;
			reply.found_average = '0;
			case (cmd.kind)
				KIND_CLEAR: begin
					used = 0;
				end
				KIND_INSERT: begin
					if (find_key(key, pos)) begin
						averages[pos] = avg;
					end else if (used >= ENTRIES) begin
						reply.status = STATUS_FULL;
					end else begin
						for (int i = used; i > pos; i--) begin
							family_keys[i] = family_keys[i-1];
							given_keys[i] = given_keys[i-1];
							averages[i] = averages[i-1];
						end
						{family_keys[pos], given_keys[pos]} = key;
						averages[pos] = avg;
						used++;
					end
				end
				KIND_LOOKUP: begin
					if (find_key(key, pos))
						reply.found_average = averages[pos];
					else
						reply.status = STATUS_NOT_FOUND;
				end
				default: begin
				end
			endcase
			expected_replies.push_back(reply);
		endfunction

		function void check_reply(input out_item_t got);
			out_item_t want;
			if (expected_replies.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result with nothing pending: status %0d average %0d",
						$time, got.status, got.found_average);
				return;
			end
			want = expected_replies.pop_front();
			if (got.status !== want.status || got.found_average !== want.found_average) begin
				failures++;
				if (failures <= 10)
					$display("%0t: mismatch: status %0d (expected %0d), average %0d (expected %0d)",
						$time, got.status, want.status, got.found_average,
						want.found_average);
			end
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	table_scoreboard board;
	int              ops_issued;
	int              ops_target;
	// Set by the stimulus to ask the receiver for one long hold-off.
	bit              long_hold;
	// While set, the sender offers commands back to back.
	bit              sender_steady;

	sorted_name_table_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// Packs a short string big-endian and zero padded, the way names are keyed.
	function automatic logic [NAME_W-1:0] text_key(input string s);
		logic [NAME_W-1:0] k;
		k = '0;
		for (int i = 0; i < s.len() && i < 8; i++)
			k[NAME_W-1-8*i -: 8] = s[i];
		return k;
	endfunction

	// Mostly lowercase names of random length, with some raw 64-bit patterns
	// and the extremes mixed in so every bit of the name fields toggles.
	function automatic logic [NAME_W-1:0] random_name();
		logic [NAME_W-1:0] k;
		int                len;
		k = '0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					k[NAME_W-1-8*i -: 8] = 8'($urandom_range(97, 122));
			end
			6, 7: k = {$urandom, $urandom};
			8: begin
				case ($urandom_range(0, 3))
					0: k = '0;
					1: k = NAME_ONES;
					2: k = 64'h1;
					default: k = 64'h8000_0000_0000_0000;
				endcase
			end
			default: k[NAME_W-1 -: 8] = 8'($urandom_range(0, 255));
		endcase
		return k;
	endfunction

	// Averages mostly in range, with the saturating values above 1000 and
	// both ends of the range appearing regularly.
	function automatic logic [AVG_W-1:0] random_average();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return AVG_W'($urandom_range(1001, 1023));
		if (r < 15)
			return AVG_MAX;
		if (r < 20)
			return '0;
		return AVG_W'($urandom_range(0, 1000));
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	// Offers one command and holds it until the block takes it. The caller is
	// always at a rising edge here, so valid is raised exactly once per step.
	// After the transfer an optional random gap lowers valid.
	task automatic submit(input logic [KIND_W-1:0] kind, input logic [NAME_W-1:0] fam,
			input logic [NAME_W-1:0] giv, input logic [AVG_W-1:0] avg);
		in_item_t cmd;
		int       gap;
		cmd.kind = kind;
		cmd.family_name = fam;
		cmd.given_name = giv;
		cmd.grade_average = avg;
		in_valid <= 1'b1;
		in_data <= cmd;
		do @(posedge clk); while (!(in_valid && !in_stall));
		board.note_command(cmd);
		if (kind != KIND_UNUSED)
			ops_issued++;
		gap = sender_steady ? 0 : sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender pause: nothing is offered until every pending reply is back.
	// The loop waits on the clock before it checks, so valid is never dropped and raised at once.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// One stretch of random traffic over a pool of names. Most commands hit
	// the pool, so inserts collide and lookups succeed; the rest are misses,
	// random inserts, unused codes and clears. A fill stretch first pushes
	// more distinct names than the table holds, exercising the full case.
	task automatic run_episode(input int pool_size, input int length, input bit fill);
		logic [NAME_W-1:0] pool_family[POOL_DEPTH];
		logic [NAME_W-1:0] pool_given[POOL_DEPTH];
		int                pick;
		int                r;
		for (int i = 0; i < pool_size; i++) begin
			// Shared family names check the ordering on the given name.
			if (i > 0 && $urandom_range(0, 3) == 0)
				pool_family[i] = pool_family[i-1];
			else
				pool_family[i] = random_name();
			pool_given[i] = random_name();
		end
		if (fill) begin
			submit(KIND_CLEAR, random_name(), random_name(), random_average());
			for (int i = 0; i < pool_size; i++)
				submit(KIND_INSERT, pool_family[i], pool_given[i], random_average());
		end
		for (int n = 0; n < length && ops_issued < ops_target; n++) begin
			pick = $urandom_range(0, pool_size - 1);
			r = $urandom_range(0, 99);
			if (r < 45)
				submit(KIND_INSERT, pool_family[pick], pool_given[pick], random_average());
			else if (r < 85)
				submit(KIND_LOOKUP, pool_family[pick], pool_given[pick], random_average());
			else if (r < 93)
				submit(KIND_LOOKUP, random_name(), random_name(), random_average());
			else if (r < 96)
				submit(KIND_UNUSED, random_name(), random_name(), random_average());
			else if (r < 98 || fill)
				submit(KIND_INSERT, random_name(), random_name(), random_average());
			else
				submit(KIND_CLEAR, random_name(), random_name(), random_average());
		end
	endtask

	// Every reply the block offers and the testbench takes is checked.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_reply(out_data);
	end

	// Receiver side: random stall bursts, long runs with no stall, and on
	// request one long hold-off that lets the block back up into its input.
	initial begin
		int r;
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				r = $urandom_range(0, 9);
				if (r < 5) begin
					out_stall <= 1'b0;
					n = $urandom_range(1, 20);
				end else if (r < 8) begin
					out_stall <= 1'b1;
					n = $urandom_range(1, 3);
				end else if (r == 8) begin
					out_stall <= 1'b1;
					n = $urandom_range(10, 40);
				end else begin
					out_stall <= 1'b0;
					n = $urandom_range(50, 100);
				end
				repeat (n) @(posedge clk);
			end
		end
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#8_000_000;
		$display("FAIL sorted_name_table_lookup");
		$finish;
	end

	initial begin
		int ep;
		bit fill;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		long_hold = 1'b0;
		sender_steady = 1'b0;
		ops_issued = 0;
		ops_target = 0;
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed commands: empty table, extremes of names and averages,
		// ordering on the given name, duplicate replacement, saturation,
		// missing keys, the unused code and a clear.
		submit(KIND_LOOKUP, '0, '0, '0);
		submit(KIND_UNUSED, NAME_ONES, NAME_ONES, '1);
		submit(KIND_INSERT, '0, '0, '0);
		submit(KIND_INSERT, NAME_ONES, NAME_ONES, AVG_MAX);
		submit(KIND_INSERT, text_key("smith"), text_key("john"), 10'd1023);
		submit(KIND_INSERT, text_key("smith"), text_key("anna"), 10'd512);
		submit(KIND_INSERT, text_key("adams"), text_key("zoe"), 10'd1);
		submit(KIND_LOOKUP, text_key("smith"), text_key("john"), '0);
		submit(KIND_LOOKUP, text_key("smith"), text_key("anna"), '0);
		submit(KIND_LOOKUP, '0, '0, '1);
		submit(KIND_LOOKUP, NAME_ONES, NAME_ONES, '0);
		submit(KIND_INSERT, text_key("smith"), text_key("john"), 10'd333);
		submit(KIND_LOOKUP, text_key("smith"), text_key("john"), '0);
		submit(KIND_LOOKUP, text_key("smith"), text_key("jon"), '0);
		submit(KIND_LOOKUP, NAME_ONES, '0, '0);
		submit(KIND_INSERT, text_key("lee"), text_key("kim"), 10'd1001);
		submit(KIND_LOOKUP, text_key("lee"), text_key("kim"), '0);
		submit(KIND_LOOKUP, text_key("adams"), text_key("zoe"), '0);
		submit(KIND_UNUSED, text_key("adams"), text_key("zoe"), 10'd77);
		submit(KIND_CLEAR, NAME_ONES, NAME_ONES, '1);
		submit(KIND_LOOKUP, text_key("smith"), text_key("john"), '0);
		submit(KIND_INSERT, text_key("smith"), text_key("john"), 10'd640);
		submit(KIND_LOOKUP, text_key("smith"), text_key("john"), '0);
		drain();

		// Random traffic in stretches. Some stretches run back to back, two
		// of them start while the receiver is held off, and fill stretches
		// drive the table past capacity.
		ops_target = ops_issued + RANDOM_OPS;
		ep = 0;
		while (ops_issued < ops_target) begin
			sender_steady = (ep % 4 == 3);
			if (ep == 1 || ep == 6)
				long_hold = 1'b1;
			fill = (ep == 2 || ep % 9 == 8);
			if (!fill && $urandom_range(0, 2) == 0)
				submit(KIND_CLEAR, random_name(), random_name(), random_average());
			run_episode(fill ? ENTRIES + 24 : $urandom_range(4, 40),
				$urandom_range(40, 120), fill);
			if (ep % 3 == 2)
				drain();
			ep++;
		end
		sender_steady = 1'b0;

		// Let the last replies come back, then keep watching for any stray
		// transfer before the verdict.
		drain();
		repeat (20) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0)
			$display("PASS sorted_name_table_lookup");
		else
			$display("FAIL sorted_name_table_lookup");
		$finish;
	end
endmodule
